/* design/llf_pkg.sv */
package llf_pkg;

    // Field and datapath widths
    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned TICK_W   = 14;
    localparam int unsigned CFG_AW   = 3;
    localparam int unsigned SUM_W    = 33;          // cycle time plus a time constant
    localparam int unsigned PROD_W   = 65;          // 32 x 33 partial product
    localparam int unsigned ACC_W    = 98;          // signed numerator accumulator
    localparam int unsigned DEN_W    = SUM_W + 16;  // divisor, times scaled by 2^16
    localparam int unsigned QUO_W    = 32;          // quotient bits before saturation

    // Register indexes of the configuration port
    localparam logic [CFG_AW-1:0] CFG_LAG_TIME   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_LEAD_TIME  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_GAIN       = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_CYCLE_TIME = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RESET_VAL  = 3'd4;

    // Register reset values
    localparam logic [31:0] DEFAULT_CYCLE_US = 32'd1000000;
    localparam logic [31:0] DEFAULT_GAIN     = 32'h0001_0000;   // 1.0 in Q16.16

    // Tick counter wraps after this value
    localparam logic [TICK_W-1:0] TICK_LAST = 14'd9999;

    // Saturation limits
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Last division step
    localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

    // Multiply sequence: two gain products, then the numerator partial products
    typedef enum logic [2:0] {
        MS_KU     = 3'd0,
        MS_KUO    = 3'd1,
        MS_KU_LO  = 3'd2,
        MS_KU_HI  = 3'd3,
        MS_KUO_LO = 3'd4,
        MS_KUO_HI = 3'd5,
        MS_VO     = 3'd6,
        MS_DRAIN  = 3'd7
    } t_mul_step;

    // Weight of a partial product in the accumulator
    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2
    } t_acc_shift;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load;
        logic      mul;
        t_mul_step mul_step;
        logic      div_init;
        logic      div_step;
        logic      commit;
    } t_dp_cmd;

    // Magnitude of a signed 32-bit value; -2^31 maps to 2^31
    function automatic logic [31:0] abs32(input logic [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

/* design/llf_ctrl.sv */
module llf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,      // input word accepted this cycle
    input  logic              i_compute,    // word asks for the filter equation
    input  logic              i_out_free,   // output register can take a word
    output logic              o_ready,
    output llf_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_cmd.load      = 1'b0;
        o_cmd.mul       = 1'b0;
        o_cmd.mul_step  = llf_pkg::t_mul_step'(r_cnt[2:0]);
        o_cmd.div_init  = 1'b0;
        o_cmd.div_step  = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_compute ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (o_cmd.mul_step == llf_pkg::MS_DRAIN) begin
                    n_cnt   = '0;
                    n_state = S_PREP;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_PREP: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == llf_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

`ifndef NO_ASSERTIONS
    a_start_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_start && i_compute) |=> (r_state == S_MUL && r_cnt == 5'd0))
        else $error("compute word did not start the multiply sequence");

    a_start_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_start && !i_compute) |=> (r_state == S_DONE))
        else $error("held or disabled word did not go straight to commit");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == llf_pkg::DIV_LAST) |=> (r_state == S_DONE))
        else $error("division did not end after the last quotient bit");

    a_commit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (o_ready && !o_cmd.commit))
        else $error("commit not followed by idle");
`endif

endmodule

/* design/llf_dp.sv */
module llf_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  llf_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_cfg_we,
    input  logic [llf_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic [llf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                         i_enable,
    input  logic                         i_hold,
    output logic [llf_pkg::SAMPLE_W-1:0] o_value,   // output value of this word
    output logic                         o_enable,
    output logic [llf_pkg::TICK_W-1:0]   o_tick     // tick count after increment
);

    // Configuration registers
    logic [31:0] r_lag, r_lead, r_gain, r_cyc, r_rstv;

    // Captured input word and derived sums
    logic [31:0]                r_u;
    logic                       r_en, r_hold;
    logic [llf_pkg::SUM_W-1:0]  r_ctd;      // cycle + lead time
    logic [llf_pkg::SUM_W-1:0]  r_den;      // cycle + lag time

    // Filter state
    logic [31:0]                r_uo, r_vo;
    logic [llf_pkg::TICK_W-1:0] r_tick;

    // Multiply and accumulate
    logic [63:0]                r_ku, r_kuo;
    logic                       r_ku_neg, r_kuo_neg;
    logic [llf_pkg::PROD_W-1:0] r_prod;
    logic                       r_prod_neg, r_prod_vld;
    llf_pkg::t_acc_shift        r_prod_sh;
    logic [llf_pkg::ACC_W-1:0]  r_acc;

    // Divider
    logic                        r_neg, r_ovf;
    logic [llf_pkg::DEN_W-1:0]   r_rem;
    logic [llf_pkg::QUO_W-1:0]   r_quo;

    logic [31:0]                 cyc_eff;
    logic [31:0]                 op_a;
    logic [llf_pkg::SUM_W-1:0]   op_b;
    logic                        op_neg, op_acc;
    llf_pkg::t_acc_shift         op_sh;
    logic [llf_pkg::PROD_W-1:0]  prod;
    logic [llf_pkg::ACC_W-1:0]   term, mag;
    logic [llf_pkg::DEN_W-1:0]   den;
    logic [llf_pkg::DEN_W:0]     trial, diff;
    logic                        ge;
    logic [31:0]                 sat;
    logic [31:0]                 n_vo;
    logic [llf_pkg::TICK_W-1:0]  n_tick;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag  <= '0;
            r_lead <= '0;
            r_gain <= llf_pkg::DEFAULT_GAIN;
            r_cyc  <= llf_pkg::DEFAULT_CYCLE_US;
            r_rstv <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                llf_pkg::CFG_LAG_TIME:   r_lag  <= i_cfg_wdata;
                llf_pkg::CFG_LEAD_TIME:  r_lead <= i_cfg_wdata;
                llf_pkg::CFG_GAIN:       r_gain <= i_cfg_wdata;
                llf_pkg::CFG_CYCLE_TIME: r_cyc  <= i_cfg_wdata;
                llf_pkg::CFG_RESET_VAL:  r_rstv <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero cycle time falls back to one second
    assign cyc_eff = (r_cyc == '0) ? llf_pkg::DEFAULT_CYCLE_US : r_cyc;

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u    <= i_sample;
            r_en   <= i_enable;
            r_hold <= i_hold;
            r_ctd  <= {1'b0, cyc_eff} + {1'b0, r_lead};
            r_den  <= {1'b0, cyc_eff} + {1'b0, r_lag};
        end
    end

    // Operand select for the shared multiplier
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_neg = 1'b0;
        op_acc = 1'b0;
        op_sh  = llf_pkg::SH_0;
        unique case (i_cmd.mul_step)
            llf_pkg::MS_KU: begin
                op_a = llf_pkg::abs32(r_gain);
                op_b = {1'b0, llf_pkg::abs32(r_u)};
            end
            llf_pkg::MS_KUO: begin
                op_a = llf_pkg::abs32(r_gain);
                op_b = {1'b0, llf_pkg::abs32(r_uo)};
            end
            llf_pkg::MS_KU_LO: begin
                op_a   = r_ku[31:0];
                op_b   = r_ctd;
                op_neg = r_ku_neg;
                op_acc = 1'b1;
            end
            llf_pkg::MS_KU_HI: begin
                op_a   = r_ku[63:32];
                op_b   = r_ctd;
                op_neg = r_ku_neg;
                op_acc = 1'b1;
                op_sh  = llf_pkg::SH_32;
            end
            // the previous-input term is subtracted
            llf_pkg::MS_KUO_LO: begin
                op_a   = r_kuo[31:0];
                op_b   = {1'b0, r_lead};
                op_neg = !r_kuo_neg;
                op_acc = 1'b1;
            end
            llf_pkg::MS_KUO_HI: begin
                op_a   = r_kuo[63:32];
                op_b   = {1'b0, r_lead};
                op_neg = !r_kuo_neg;
                op_acc = 1'b1;
                op_sh  = llf_pkg::SH_32;
            end
            llf_pkg::MS_VO: begin
                op_a   = llf_pkg::abs32(r_vo);
                op_b   = {1'b0, r_lag};
                op_neg = r_vo[31];
                op_acc = 1'b1;
                op_sh  = llf_pkg::SH_16;
            end
            llf_pkg::MS_DRAIN: ;
            default: ;
        endcase
    end

    assign prod = {33'b0, op_a} * {32'b0, op_b};

    // Product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul && i_cmd.mul_step == llf_pkg::MS_KU) begin
            r_ku     <= prod[63:0];
            r_ku_neg <= r_gain[31] ^ r_u[31];
        end
        if (i_cmd.mul && i_cmd.mul_step == llf_pkg::MS_KUO) begin
            r_kuo     <= prod[63:0];
            r_kuo_neg <= r_gain[31] ^ r_uo[31];
        end
        if (i_cmd.mul && op_acc) begin
            r_prod     <= prod;
            r_prod_neg <= op_neg;
            r_prod_sh  <= op_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul && op_acc;
        end
    end

    // Align the registered partial product
    always_comb begin
        unique case (r_prod_sh)
            llf_pkg::SH_0:  term = {33'b0, r_prod};
            llf_pkg::SH_16: term = {17'b0, r_prod, 16'b0};
            llf_pkg::SH_32: term = {1'b0, r_prod, 32'b0};
            default:        term = '0;
        endcase
    end

    // Numerator accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_neg ? (r_acc - term) : (r_acc + term);
        end
    end

    // Restoring divider: magnitude of the numerator over (cycle + lag) * 2^16
    assign mag   = r_acc[llf_pkg::ACC_W-1] ? (~r_acc + 98'd1) : r_acc;
    assign den   = {r_den, 16'b0};
    assign trial = {r_rem, r_quo[llf_pkg::QUO_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_neg <= r_acc[llf_pkg::ACC_W-1];
            // quotient of 2^32 or more saturates either way
            r_ovf <= (mag[97:32] >= {17'b0, den});
            r_rem <= mag[80:32];
            r_quo <= mag[31:0];
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[llf_pkg::DEN_W-1:0] : trial[llf_pkg::DEN_W-1:0];
            r_quo <= {r_quo[llf_pkg::QUO_W-2:0], ge};
        end
    end

    // Sign and saturation
    always_comb begin
        if (r_ovf) begin
            sat = r_neg ? llf_pkg::SAT_MIN : llf_pkg::SAT_MAX;
        end else if (r_neg) begin
            sat = (r_quo > llf_pkg::SAT_MIN) ? llf_pkg::SAT_MIN : (~r_quo + 32'd1);
        end else begin
            sat = r_quo[31] ? llf_pkg::SAT_MAX : r_quo;
        end
    end

    assign n_vo   = !r_en ? r_vo : (r_hold ? r_rstv : sat);
    assign n_tick = (r_tick == llf_pkg::TICK_LAST) ? '0 : (r_tick + 14'd1);

    // Filter state update at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uo   <= '0;
            r_vo   <= '0;
            r_tick <= '0;
        end else if (i_cmd.commit) begin
            r_uo   <= r_u;
            r_vo   <= n_vo;
            r_tick <= n_tick;
        end
    end

    assign o_value  = n_vo;
    assign o_enable = r_en;
    assign o_tick   = n_tick;

endmodule

/* design/lead_lag_first_order_filter.sv */
// Lead-lag filter, one output word per input word.
// With enable set and hold reset clear, a word runs the multiply sequence, a
// divider setup step, the divide steps and commit; a held or disabled word goes
// straight to commit. Commit waits while the output register is full, and a new
// word is accepted only after it (one-bit-per-cycle divider, shared multiplier).
// Reset (synchronous, active low) restores register defaults and clears state.
module lead_lag_first_order_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    input  logic [1:0]  s_axis_tuser,   // [0] enable, [1] hold_reset
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] output_value, [45:32] tick_count, pad
    output logic [0:0]  m_axis_tuser,   // [0] enable_out
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    llf_pkg::t_dp_cmd            cmd;
    logic                        ready, start, out_free;
    logic [31:0]                 value;
    logic                        enable_out;
    logic [llf_pkg::TICK_W-1:0]  tick;

    logic                        r_out_vld;
    logic [47:0]                 r_out_data;
    logic                        r_out_user;

    assign s_axis_tready = ready;
    assign start         = s_axis_tvalid && ready;
    assign out_free      = !r_out_vld || m_axis_tready;

    llf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_compute  (s_axis_tuser[0] && !s_axis_tuser[1]),
        .i_out_free (out_free),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    llf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .i_enable    (s_axis_tuser[0]),
        .i_hold      (s_axis_tuser[1]),
        .o_value     (value),
        .o_enable    (enable_out),
        .o_tick      (tick)
    );

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.commit) begin
            r_out_data <= {2'b0, tick, value};
            r_out_user <= enable_out;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

endmodule

/* tb/lead_lag_first_order_filter_tb.sv */
module lead_lag_first_order_filter_tb;

    localparam int WORDS_PER_SET   = 120;
    localparam int SET_COUNT       = 9;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int DRAIN_CYCLES    = 50;

    typedef struct packed {
        logic [31:0] sample;
        logic        enable;
        logic        hold;
    } t_sample_word;

    typedef struct packed {
        logic [31:0]                value;
        logic [llf_pkg::TICK_W-1:0] tick;
        logic                       enable;
    } t_filter_out;

    // DUT ports, inputs all known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we      = 1'b0;
    logic [2:0]  i_cfg_addr    = '0;
    logic [31:0] i_cfg_wdata   = '0;

    lead_lag_first_order_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow registers and filter state
    logic [31:0]                lag_time   = '0;
    logic [31:0]                lead_time  = '0;
    logic [31:0]                gain       = llf_pkg::DEFAULT_GAIN;
    logic [31:0]                cycle_time = llf_pkg::DEFAULT_CYCLE_US;
    logic [31:0]                hold_value = '0;
    logic [31:0]                last_input  = '0;
    logic [31:0]                last_output = '0;
    logic [llf_pkg::TICK_W-1:0] tick_pred   = '0;

    t_sample_word pending_words[$];
    t_filter_out  expected_outputs[$];

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int err_cnt           = 0;
    bit stall_go          = 1'b0;
    int stall_left        = 0;

    // Exact quotient of the lead-lag update, truncated toward zero, saturated
    function automatic logic [31:0] lead_lag_value(input logic [31:0] u);
        logic signed [129:0] lag, lead, per, kp, us, uo, vo, num, den, quo;
        lag  = {98'd0, lag_time};
        lead = {98'd0, lead_time};
        per  = (cycle_time == '0) ? {98'd0, llf_pkg::DEFAULT_CYCLE_US} : {98'd0, cycle_time};
        kp   = {{98{gain[31]}}, gain};
        us   = {{98{u[31]}}, u};
        uo   = {{98{last_input[31]}}, last_input};
        vo   = {{98{last_output[31]}}, last_output};
        num  = lag * vo * 130'sd65536 + kp * us * (per + lead) - kp * uo * lead;
        den  = (per + lag) * 130'sd65536;
        quo  = num / den;
        if (quo > 130'sd2147483647)
            return llf_pkg::SAT_MAX;
        if (quo < -130'sd2147483648)
            return llf_pkg::SAT_MIN;
        return quo[31:0];
    endfunction

    // One tick of the filter: output, enable copy, counter
    function automatic t_filter_out filter_step(input logic [31:0] u, input logic en,
                                                input logic hold);
        t_filter_out r;
        logic [31:0] v;
        v = last_output;
        if (en)
            v = hold ? hold_value : lead_lag_value(u);
        last_input  = u;
        last_output = v;
        tick_pred   = (tick_pred == llf_pkg::TICK_LAST) ? '0 : tick_pred + 1'b1;
        r.value  = v;
        r.tick   = tick_pred;
        r.enable = en;
        return r;
    endfunction

    // Driver: offer queued words, predict on each accepted word
    always @(posedge i_clk) begin : driver
        t_sample_word w;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_outputs.push_back(filter_step(s_axis_tdata, s_axis_tuser[0],
                                                       s_axis_tuser[1]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    w = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= w.sample;
                    s_axis_tuser  <= {w.hold, w.enable};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (stall_go)
            stall_left <= HOLD_OFF_CYCLES;
    end

    // Monitor: compare each output word with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_filter_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outputs.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected output word, expected none, actual %h/%h",
                             $time, m_axis_tdata, m_axis_tuser);
                end else begin
                    want = expected_outputs.pop_front();
                    if (m_axis_tdata[31:0] !== want.value) begin
                        err_cnt++;
                        $display("%0t: output_value expected %h actual %h",
                                 $time, want.value, m_axis_tdata[31:0]);
                    end
                    if (m_axis_tdata[45:32] !== want.tick) begin
                        err_cnt++;
                        $display("%0t: tick_count expected %0d actual %0d",
                                 $time, want.tick, m_axis_tdata[45:32]);
                    end
                    if (m_axis_tuser[0] !== want.enable) begin
                        err_cnt++;
                        $display("%0t: enable_out expected %b actual %b",
                                 $time, want.enable, m_axis_tuser[0]);
                    end
                end
            end
            m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic add_word(input logic [31:0] sample, input logic en, input logic hold);
        t_sample_word w;
        w.sample = sample;
        w.enable = en;
        w.hold   = hold;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            llf_pkg::CFG_LAG_TIME:   lag_time   = val;
            llf_pkg::CFG_LEAD_TIME:  lead_time  = val;
            llf_pkg::CFG_GAIN:       gain       = val;
            llf_pkg::CFG_CYCLE_TIME: cycle_time = val;
            llf_pkg::CFG_RESET_VAL:  hold_value = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // All five registers, then a write to an unused index that must be ignored
    task automatic apply_settings(input logic [31:0] t1, input logic [31:0] td,
                                  input logic [31:0] kp, input logic [31:0] cyc,
                                  input logic [31:0] rv);
        write_reg(llf_pkg::CFG_LAG_TIME, t1);
        write_reg(llf_pkg::CFG_LEAD_TIME, td);
        write_reg(llf_pkg::CFG_GAIN, kp);
        write_reg(llf_pkg::CFG_CYCLE_TIME, cyc);
        write_reg(llf_pkg::CFG_RESET_VAL, rv);
        write_reg(llf_pkg::CFG_RESET_VAL + 3'($urandom_range(3, 1)), $urandom);
        @(negedge i_clk);
    endtask

    // Block idle: nothing queued, offered or outstanding
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0:       return 32'($signed($urandom_range(2097151)) - 1048576);
            1:       return 32'($signed($urandom_range(524288)) - 262144);
            2: begin
                case ($urandom_range(3))
                    0:       return llf_pkg::SAT_MAX;
                    1:       return llf_pkg::SAT_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0:       return '0;
            1:       return $urandom_range(2000000);
            2:       return $urandom_range(200);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(1))
            return 32'($signed($urandom_range(524288)) - 262144);
        return $urandom;
    endfunction

    // Mostly computing ticks, some held, some disabled
    task automatic add_random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 80)
            add_word(rand_sample(), 1'b1, 1'b0);
        else if (pick < 88)
            add_word(rand_sample(), 1'b1, 1'b1);
        else
            add_word(rand_sample(), 1'b0, 1'($urandom_range(1)));
    endtask

    // Stimulus
    initial begin
        int set_idx, n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: unity gain, no lead or lag, so the output follows u
        add_word(llf_pkg::SAT_MAX, 1'b1, 1'b0);
        add_word(llf_pkg::SAT_MIN, 1'b1, 1'b0);
        add_word('0, 1'b1, 1'b0);
        add_word('1, 1'b1, 1'b0);
        add_word(32'h0001_0000, 1'b1, 1'b0);
        add_word(32'h5555_5555, 1'b1, 1'b0);
        add_word(32'hAAAA_AAAA, 1'b1, 1'b0);
        add_word(32'h1234_5678, 1'b1, 1'b1);
        // disabled with hold reset: output holds
        add_word(32'h0F0F_0F0F, 1'b0, 1'b1);
        add_word(32'h7654_3210, 1'b0, 1'b0);
        wait_idle();

        // Zero cycle time falls back to one second; most negative gain
        apply_settings(32'd500000, 32'd250000, llf_pkg::SAT_MIN, '0, llf_pkg::SAT_MAX);
        add_word(llf_pkg::SAT_MAX, 1'b1, 1'b0);
        add_word(llf_pkg::SAT_MIN, 1'b1, 1'b0);
        add_word('0, 1'b1, 1'b0);
        add_word(32'h0000_8000, 1'b1, 1'b0);
        add_word(32'hFFFF_0000, 1'b1, 1'b0);
        add_word(llf_pkg::SAT_MIN, 1'b1, 1'b1);
        add_word(llf_pkg::SAT_MAX, 1'b0, 1'b1);
        add_word(32'h0001_0000, 1'b1, 1'b0);
        wait_idle();

        for (set_idx = 0; set_idx < SET_COUNT; set_idx++) begin
            // idle pattern per third of the sets
            if (set_idx < 3) begin
                sender_idle_pct   = 11;
                receiver_idle_pct = 86;
            end else if (set_idx < 6) begin
                sender_idle_pct   = 86;
                receiver_idle_pct = 11;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (set_idx)
                0: apply_settings(32'd1000000, '0, llf_pkg::DEFAULT_GAIN, 32'd100000,
                                  32'h0001_0000);
                1: apply_settings('0, 32'd2000000, 32'h0002_0000, 32'd10000, '1);
                2: apply_settings('1, '1, llf_pkg::SAT_MAX, '1, llf_pkg::SAT_MAX);
                3: apply_settings('0, '0, llf_pkg::SAT_MIN, 32'd1, llf_pkg::SAT_MIN);
                5: apply_settings(rand_time(), rand_time(), rand_gain(), '0, $urandom);
                6: apply_settings(32'd1, '1, 32'hFFFF_0000, 32'd1, $urandom);
                default: apply_settings(rand_time(), rand_time(), rand_gain(), rand_time(),
                                        $urandom);
            endcase
            for (n = 0; n < WORDS_PER_SET; n++)
                add_random_word();
            if (set_idx == SET_COUNT - 1) begin
                // receiver holds off while the sender keeps offering
                stall_go = 1'b1;
                do @(negedge i_clk); while (stall_left == 0);
                stall_go = 1'b0;
            end
            wait_idle();
        end

        add_word(rand_sample(), 1'b1, 1'b0);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0)
            $display("lead_lag_first_order_filter_tb: done, clean");
        else
            $display("lead_lag_first_order_filter_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #10000000;
        $display("lead_lag_first_order_filter_tb: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
design/llf_pkg.sv
design/llf_ctrl.sv
design/llf_dp.sv
design/lead_lag_first_order_filter.sv
tb/lead_lag_first_order_filter_tb.sv
